// ===== rtl/cigar_overlap_trim_merge_assert.svh =====
// Assertion macros for the CIGAR overlap trim and merge block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef CIGAR_OVERLAP_TRIM_MERGE_ASSERT_SVH
`define CIGAR_OVERLAP_TRIM_MERGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define COTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define COTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cotm_pkg.sv =====
// Package for the CIGAR overlap trim and merge block.
// Holds op codes, payload and queue entry types, and saturating add.
// No dependencies.
package cotm_pkg;

  localparam int LengthBits    = 28;
  localparam int CodeBits      = 4;
  localparam int QueueDepthDef = 2;

  typedef logic [LengthBits-1:0] len_t;
  typedef logic [CodeBits-1:0]   code_t;

  localparam len_t LenMax = '1;

  localparam code_t OpM  = 4'd0;
  localparam code_t OpI  = 4'd1;
  localparam code_t OpD  = 4'd2;
  localparam code_t OpN  = 4'd3;
  localparam code_t OpS  = 4'd4;
  localparam code_t OpH  = 4'd5;
  localparam code_t OpP  = 4'd6;
  localparam code_t OpEq = 4'd7;
  localparam code_t OpX  = 4'd8;
  localparam code_t OpJ  = 4'd9;

  typedef struct packed {
    code_t op_code;
    len_t  op_length;
    logic  from_second;
    len_t  skip_len;
    logic  last_op;
  } in_t;

  typedef struct packed {
    code_t out_code;
    len_t  out_length;
    len_t  skipped_read_len;
    logic  bad_op;
    logic  last_out;
  } out_t;

  // Classified op handed from front to back.
  typedef struct packed {
    logic  have;
    code_t code;
    len_t  elen;
    logic  last;
    len_t  skipped;
    logic  bad;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic len_t sat_add(len_t a, len_t b);
    logic [LengthBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LengthBits] ? LenMax : s[LengthBits-1:0];
  endfunction

  function automatic logic is_read_op(code_t c);
    return (c == OpM) || (c == OpEq) || (c == OpX);
  endfunction

endpackage

// ===== rtl/cotm_front.sv =====
// Front stage: accepts ops, trims the mate's overlap and tracks counts.
// Depends on cotm_pkg.
module cotm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cotm_pkg::in_t      in_data_i,
  input  cotm_pkg::q_status_t q_status_i,
  output logic               push_o,
  output cotm_pkg::entry_t   push_data_o
);

  logic            seg_q, seg_d;
  cotm_pkg::len_t  rem_q, rem_d;
  cotm_pkg::len_t  skd_q, skd_d;
  logic            err_q, err_d;

  logic            seg;
  cotm_pkg::len_t  rem, rem_n, used, skd_n, elen;
  logic            err_n, have, longer;

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    seg    = seg_q | in_data_i.from_second;
    rem    = (in_data_i.from_second && !seg_q) ? in_data_i.skip_len : rem_q;
    longer = in_data_i.op_length > rem;
    used   = longer ? rem : in_data_i.op_length;
    have   = 1'b0;
    elen   = '0;
    rem_n  = rem;
    skd_n  = skd_q;
    err_n  = err_q;
    if (in_data_i.op_code > cotm_pkg::OpJ) begin
      err_n = 1'b1;
    end else if (seg && (rem != '0)) begin
      case (in_data_i.op_code)
        cotm_pkg::OpM, cotm_pkg::OpEq, cotm_pkg::OpX,
        cotm_pkg::OpD, cotm_pkg::OpN: begin
          if (cotm_pkg::is_read_op(in_data_i.op_code)) begin
            skd_n = cotm_pkg::sat_add(skd_q, used);
          end
          if (longer) begin
            have = 1'b1;
            elen = in_data_i.op_length - rem;
          end
          rem_n = rem - used;
        end
        cotm_pkg::OpI, cotm_pkg::OpS, cotm_pkg::OpH: begin
          skd_n = cotm_pkg::sat_add(skd_q, in_data_i.op_length);
        end
        cotm_pkg::OpP: begin
          have = 1'b0;
        end
        default: begin
          err_n = 1'b1;
        end
      endcase
    end else begin
      have = 1'b1;
      elen = in_data_i.op_length;
    end

    push_data_o.have    = have;
    push_data_o.code    = in_data_i.op_code;
    push_data_o.elen    = elen;
    push_data_o.last    = in_data_i.last_op;
    push_data_o.skipped = skd_n;
    push_data_o.bad     = err_n;

    seg_d = seg_q;
    rem_d = rem_q;
    skd_d = skd_q;
    err_d = err_q;
    if (push_o) begin
      if (in_data_i.last_op) begin
        seg_d = 1'b0;
        rem_d = '0;
        skd_d = '0;
        err_d = 1'b0;
      end else begin
        seg_d = seg;
        rem_d = rem_n;
        skd_d = skd_n;
        err_d = err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= 1'b0;
      rem_q <= '0;
      skd_q <= '0;
      err_q <= 1'b0;
    end else begin
      seg_q <= seg_d;
      rem_q <= rem_d;
      skd_q <= skd_d;
      err_q <= err_d;
    end
  end

endmodule

// ===== rtl/cotm_queue.sv =====
// Short FIFO of classified ops between front and back.
// Depends on cotm_pkg.
module cotm_queue #(
  parameter int Depth = cotm_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cotm_pkg::entry_t    push_data_i,
  input  logic                pop_i,
  output cotm_pkg::q_status_t status_o,
  output cotm_pkg::entry_t    head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cotm_pkg::entry_t    mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntFull);
  assign head_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/cotm_back.sv =====
// Back stage: one-entry merge buffer and output register.
// Depends on cotm_pkg.
module cotm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cotm_pkg::q_status_t q_status_i,
  input  cotm_pkg::entry_t    head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cotm_pkg::out_t      out_data_o
);

  logic            pv_q, pv_d;
  cotm_pkg::code_t pc_q, pc_d;
  cotm_pkg::len_t  pl_q, pl_d;
  logic            split_q, split_d;
  logic            ov_q, ov_d;
  cotm_pkg::out_t  od_q, od_d;

  logic            slot, eff_have, merge, emit_pend, emit, go;
  logic            npv;
  cotm_pkg::code_t npc;
  cotm_pkg::len_t  npl;

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    slot      = !ov_q || out_ready_i;
    eff_have  = head_i.have && !split_q;
    merge     = eff_have && pv_q && (pc_q == head_i.code);
    emit_pend = eff_have && pv_q && !merge;
    emit      = emit_pend || head_i.last;
    go        = !q_status_i.empty && (!emit || slot);
    // Hold the head on a last op that must flush two results.
    pop_o     = go && !(emit_pend && head_i.last);

    npv = pv_q;
    npc = pc_q;
    npl = pl_q;
    if (eff_have) begin
      npv = 1'b1;
      if (merge) begin
        npl = cotm_pkg::sat_add(pl_q, head_i.elen);
      end else begin
        npc = head_i.code;
        npl = head_i.elen;
      end
    end

    if (emit_pend) begin
      od_d.out_code         = pc_q;
      od_d.out_length       = pl_q;
      od_d.skipped_read_len = '0;
      od_d.bad_op           = 1'b0;
      od_d.last_out         = 1'b0;
    end else begin
      od_d.out_code         = npv ? npc : cotm_pkg::OpM;
      od_d.out_length       = npv ? npl : '0;
      od_d.skipped_read_len = head_i.skipped;
      od_d.bad_op           = head_i.bad;
      od_d.last_out         = 1'b1;
    end

    ov_d    = (ov_q && !out_ready_i) || (go && emit);
    pv_d    = pv_q;
    pc_d    = pc_q;
    pl_d    = pl_q;
    split_d = split_q;
    if (go) begin
      split_d = emit_pend && head_i.last;
      if (pop_o && head_i.last) begin
        pv_d = 1'b0;
        pc_d = '0;
        pl_d = '0;
      end else begin
        pv_d = npv;
        pc_d = npc;
        pl_d = npl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      od_q <= od_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      pc_q    <= '0;
      pl_q    <= '0;
      split_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      pv_q    <= pv_d;
      pc_q    <= pc_d;
      pl_q    <= pl_d;
      split_q <= split_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ===== rtl/cigar_overlap_trim_merge.sv =====
// Throughput: one op per cycle while the queue has space; a last op that both
//   displaces the buffered op and flushes is held at the queue head while the
//   single output register takes the displaced op first. Path: an op enters the
//   queue; the back end registers any result it releases if the output is free.
// Reset: async active low; clears segment, skip, counts, queue and merge buffer.
// Depends on cotm_pkg, cotm_front, cotm_queue, cotm_back.
module cigar_overlap_trim_merge #(
  parameter int QueueDepth = cotm_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cotm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cotm_pkg::out_t out_data_o
);

  // Front -> queue: classified transaction, one per accepted op.
  logic                push;
  cotm_pkg::entry_t    push_data;
  // Queue -> back: head transaction and occupancy.
  logic                pop;
  cotm_pkg::entry_t    head;
  cotm_pkg::q_status_t q_status;

  // Front: sample skip on the first mate op, trim the overlap, count
  // skipped read bases and flag bad codes. Ready only tracks queue space.
  cotm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouple front and back so an output stall does not stop intake at once.
  cotm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .status_o    (q_status),
    .head_o      (head)
  );

  // Back: merge runs of equal codes, release the buffered op when a different
  // code arrives, and flush the final result with the pair's side info.
  cotm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/cotm_checker.sv =====
// Port-level checker for the CIGAR overlap trim and merge block, with bind.
// Depends on cotm_pkg and cigar_overlap_trim_merge_assert.svh.
`include "cigar_overlap_trim_merge_assert.svh"

module cotm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input cotm_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cotm_pkg::out_t out_data_o
);

  `COTM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `COTM_ASSERT_IMP(a_side_zero, out_valid_o && !out_data_o.last_out, (out_data_o.skipped_read_len == '0) && !out_data_o.bad_op, "side fields set on non-final result")
  `COTM_ASSERT_IMP(a_code_range, out_valid_o, out_data_o.out_code <= cotm_pkg::OpJ, "invalid op code emitted")

endmodule

bind cigar_overlap_trim_merge cotm_checker u_cotm_checker (.*);

// ===== sim/tb_cigar_overlap_trim_merge.sv =====
// Self-checking testbench for cigar_overlap_trim_merge: directed table, then random pairs.
// Model or typed rows predict each merged op; depends on cotm_pkg and the block's RTL.
module tb_cigar_overlap_trim_merge;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes above J are invalid; these bound that range.
  localparam cotm_pkg::code_t OpBadLo = 4'd10;
  localparam cotm_pkg::code_t OpBadHi = 4'd15;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 800;
  localparam int DrainCycles = 20;
  localparam int ReportMax   = 10;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  cotm_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  cotm_pkg::out_t out_data_o;

  cigar_overlap_trim_merge u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Merged ops the block still owes us, oldest first.
  cotm_pkg::out_t merged_ops_q [$];

  int unsigned cycles        = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned ops_sent      = 0;
  int unsigned random_ops    = 0;
  int unsigned directed_ops  = 0;
  int unsigned pairs_sent    = 0;
  // While set, neither side inserts bubbles.
  bit          calm          = 1'b0;

  // Append one expected result behind the ones already owed.
  function automatic void expect_result(cotm_pkg::out_t r);
    merged_ops_q = {merged_ops_q, r};
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the block's running registers for one glued pair.
  // ---------------------------------------------------------------------------
  logic            mate_seen;
  cotm_pkg::len_t  skip_left;
  cotm_pkg::len_t  read_trimmed;
  logic            buf_valid;
  cotm_pkg::code_t buf_code;
  cotm_pkg::len_t  buf_len;
  logic            err_seen;

  task automatic clear_pair_state();
    mate_seen    = 1'b0;
    skip_left    = '0;
    read_trimmed = '0;
    buf_valid    = 1'b0;
    buf_code     = cotm_pkg::OpM;
    buf_len      = '0;
    err_seen     = 1'b0;
  endtask

  function automatic cotm_pkg::len_t clamp_add(cotm_pkg::len_t a, cotm_pkg::len_t b);
    logic [cotm_pkg::LengthBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[cotm_pkg::LengthBits] ? cotm_pkg::LenMax : s[cotm_pkg::LengthBits-1:0];
  endfunction

  // Fold one op into the trim/merge state; return the merged ops it releases.
  task automatic fold_op(input cotm_pkg::in_t it, output cotm_pkg::out_t res [2],
                         output int n);
    cotm_pkg::code_t c;
    cotm_pkg::len_t  l;
    cotm_pkg::len_t  used;
    cotm_pkg::len_t  elen;
    logic            emit;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    emit   = 1'b0;
    elen   = '0;
    c      = it.op_code;
    l      = it.op_length;

    // The segment flag is sticky: sample skip on the first mate op only.
    if (it.from_second && !mate_seen) begin
      mate_seen = 1'b1;
      skip_left = it.skip_len;
    end

    if (c > cotm_pkg::OpJ) begin
      err_seen = 1'b1;
    end else if (mate_seen && skip_left != '0) begin
      case (c)
        cotm_pkg::OpM, cotm_pkg::OpEq, cotm_pkg::OpX,
        cotm_pkg::OpD, cotm_pkg::OpN: begin
          used = (l > skip_left) ? skip_left : l;
          if (c == cotm_pkg::OpM || c == cotm_pkg::OpEq || c == cotm_pkg::OpX)
            read_trimmed = clamp_add(read_trimmed, used);
          // Op crosses the end of the overlap: pass on what is left of it.
          if (l > skip_left) begin
            emit = 1'b1;
            elen = l - skip_left;
          end
          skip_left = skip_left - used;
        end
        cotm_pkg::OpI, cotm_pkg::OpS, cotm_pkg::OpH: begin
          read_trimmed = clamp_add(read_trimmed, l);
        end
        cotm_pkg::OpP: begin
        end
        default: begin
          // J inside the overlap is dropped and flagged.
          err_seen = 1'b1;
        end
      endcase
    end else begin
      emit = 1'b1;
      elen = l;
    end

    if (emit) begin
      if (buf_valid && buf_code == c) begin
        buf_len = clamp_add(buf_len, elen);
      end else begin
        if (buf_valid) begin
          res[n] = cotm_pkg::out_t'{buf_code, buf_len, '0, 1'b0, 1'b0};
          n++;
        end
        buf_valid = 1'b1;
        buf_code  = c;
        buf_len   = elen;
      end
    end

    if (it.last_op) begin
      // Flush; an empty joined CIGAR still yields one zero-length final op.
      res[n] = cotm_pkg::out_t'{buf_valid ? buf_code : cotm_pkg::OpM,
                                buf_valid ? buf_len : cotm_pkg::len_t'(0),
                                read_trimmed, err_seen, 1'b1};
      n++;
      clear_pair_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: hold valid and payload until the transaction is accepted.
  // ---------------------------------------------------------------------------
  task automatic drive_op(input cotm_pkg::in_t item, input bit typed,
                          input cotm_pkg::out_t typed_res);
    cotm_pkg::out_t res [2];
    int             n;
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Accepted at this edge; any result it releases passes through the queue and the output register.
    fold_op(item, res, n);
    if (typed) begin
      expect_result(typed_res);
    end else begin
      for (int i = 0; i < n; i++) expect_result(res[i]);
    end
    ops_sent++;
  endtask

  // Output side: random back-pressure outside the calm window.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 7);
  end

  // Check every accepted result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    cotm_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (merged_ops_q.size() == 0) begin
        if (mismatches < ReportMax)
          $display("unexpected result: code %0d len %0d skipped %0d bad %0b last %0b",
                   out_data_o.out_code, out_data_o.out_length,
                   out_data_o.skipped_read_len, out_data_o.bad_op, out_data_o.last_out);
        mismatches++;
      end else begin
        want = merged_ops_q.pop_front();
        if (out_data_o.out_code !== want.out_code ||
            out_data_o.out_length !== want.out_length ||
            out_data_o.skipped_read_len !== want.skipped_read_len ||
            out_data_o.bad_op !== want.bad_op ||
            out_data_o.last_out !== want.last_out) begin
          if (mismatches < ReportMax)
            $display({"mismatch #%0d: exp code %0d len %0d skipped %0d bad %0b last %0b",
                      " | got code %0d len %0d skipped %0d bad %0b last %0b"},
                     results_seen, want.out_code, want.out_length,
                     want.skipped_read_len, want.bad_op, want.last_out,
                     out_data_o.out_code, out_data_o.out_length,
                     out_data_o.skipped_read_len, out_data_o.bad_op, out_data_o.last_out);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               merged_ops_q.size());
      $display("tb_cigar_overlap_trim_merge: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: rows with a typed result give their expected output directly.
  // ---------------------------------------------------------------------------
  typedef struct {
    cotm_pkg::in_t  item;
    bit             typed;
    cotm_pkg::out_t res;
  } row_t;

  row_t directed_rows [$];

  function automatic cotm_pkg::in_t op_item(cotm_pkg::code_t c, cotm_pkg::len_t l,
                                            logic fs, cotm_pkg::len_t skip, logic last);
    cotm_pkg::in_t it;
    it.op_code     = c;
    it.op_length   = l;
    it.from_second = fs;
    it.skip_len    = skip;
    it.last_op     = last;
    return it;
  endfunction

  function automatic void add_row(cotm_pkg::in_t item, bit typed = 1'b0,
                                  cotm_pkg::out_t res = '0);
    row_t r;
    r.item  = item;
    r.typed = typed;
    r.res   = res;
    directed_rows = {directed_rows, r};
  endfunction

  task automatic load_directed();
    // Lone invalid op with every field at its top: empty CIGAR, error flagged.
    add_row(op_item(OpBadHi, cotm_pkg::LenMax, 1'b1, cotm_pkg::LenMax, 1'b1), 1'b1,
            cotm_pkg::out_t'{cotm_pkg::OpM, cotm_pkg::len_t'(0), cotm_pkg::len_t'(0),
                             1'b1, 1'b1});
    // Longest possible single op passes through.
    add_row(op_item(cotm_pkg::OpM, cotm_pkg::LenMax, 1'b0, '0, 1'b1), 1'b1,
            cotm_pkg::out_t'{cotm_pkg::OpM, cotm_pkg::LenMax, cotm_pkg::len_t'(0),
                             1'b0, 1'b1});
    // Mate-only insert swallowed by the overlap: all of it is skipped read.
    add_row(op_item(cotm_pkg::OpI, cotm_pkg::LenMax, 1'b1, cotm_pkg::LenMax, 1'b1), 1'b1,
            cotm_pkg::out_t'{cotm_pkg::OpM, cotm_pkg::len_t'(0), cotm_pkg::LenMax,
                             1'b0, 1'b1});
    // Op crossing the overlap end, P and J outside the overlap, zero-length tail.
    add_row(op_item(cotm_pkg::OpM,  28'd10, 1'b0, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpI,  28'd2,  1'b0, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpM,  28'd8,  1'b1, 28'd12, 1'b0));
    add_row(op_item(cotm_pkg::OpD,  28'd3,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpS,  28'd2,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpX,  28'd4,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpP,  28'd1,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpJ,  28'd2,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpM,  28'd0,  1'b1, '0,     1'b1));
    // Saturating merge, zero skip, a first-segment op after the mate began.
    add_row(op_item(cotm_pkg::OpM,  cotm_pkg::LenMax, 1'b0, '0, 1'b0));
    add_row(op_item(cotm_pkg::OpM,  28'd5,  1'b0, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpH,  28'd3,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpX,  28'd2,  1'b0, cotm_pkg::LenMax, 1'b0));
    add_row(op_item(OpBadLo,        28'd7,  1'b0, '0,     1'b1));
    // Overlap covers the whole mate, with a J dropped inside it.
    add_row(op_item(cotm_pkg::OpD,  28'd4,  1'b0, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpN,  28'd5,  1'b1, 28'd100, 1'b0));
    add_row(op_item(cotm_pkg::OpM,  28'd7,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpEq, 28'd9,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpJ,  28'd1,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpX,  28'd3,  1'b1, '0,     1'b1));
    // Zero-length ops inside the overlap change nothing.
    add_row(op_item(cotm_pkg::OpM,  28'd0,  1'b1, 28'd5,  1'b0));
    add_row(op_item(cotm_pkg::OpD,  28'd0,  1'b1, '0,     1'b0));
    add_row(op_item(cotm_pkg::OpP,  28'd0,  1'b1, '0,     1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Random pairs: mostly well-formed first/mate CIGARs, some pure noise.
  // ---------------------------------------------------------------------------
  function automatic cotm_pkg::code_t pick_code(bit noisy);
    int r;
    if (noisy) return cotm_pkg::code_t'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 35) return cotm_pkg::OpM;
    if (r < 45) return cotm_pkg::OpI;
    if (r < 55) return cotm_pkg::OpD;
    if (r < 60) return cotm_pkg::OpN;
    if (r < 68) return cotm_pkg::OpS;
    if (r < 72) return cotm_pkg::OpH;
    if (r < 76) return cotm_pkg::OpP;
    if (r < 84) return cotm_pkg::OpEq;
    if (r < 92) return cotm_pkg::OpX;
    if (r < 95) return cotm_pkg::OpJ;
    return cotm_pkg::code_t'($urandom_range(OpBadLo, OpBadHi));
  endfunction

  // Mostly short ops; a few zero, near-maximum or fully random lengths.
  function automatic cotm_pkg::len_t pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 10) return cotm_pkg::LenMax - cotm_pkg::len_t'($urandom_range(0, 3));
    if (r < 15) return cotm_pkg::len_t'($urandom);
    return cotm_pkg::len_t'($urandom_range(1, 30));
  endfunction

  task automatic drive_random_pair();
    cotm_pkg::in_t   ops [$];
    cotm_pkg::in_t   it;
    int              n1;
    int              n2;
    int              r;
    bit              noisy;
    cotm_pkg::code_t prev;
    longint          ref_total;
    cotm_pkg::len_t  skip;
    noisy     = ($urandom_range(0, 99) < 15);
    n1        = $urandom_range(0, 5);
    n2        = $urandom_range(0, 6);
    if (n1 + n2 == 0) n1 = 1;
    prev      = cotm_pkg::OpM;
    ref_total = 0;

    for (int k = 0; k < n1 + n2; k++) begin
      // Repeat the previous code now and then so merging gets exercised.
      it.op_code     = (k > 0 && $urandom_range(0, 3) == 0) ? prev : pick_code(noisy);
      it.op_length   = pick_len();
      it.from_second = noisy ? logic'($urandom_range(0, 1)) : logic'(k >= n1);
      it.skip_len    = cotm_pkg::len_t'($urandom);
      it.last_op     = (k == n1 + n2 - 1);
      if (k >= n1 && it.op_code inside {cotm_pkg::OpM, cotm_pkg::OpEq, cotm_pkg::OpX,
                                        cotm_pkg::OpD, cotm_pkg::OpN})
        ref_total += it.op_length;
      prev = it.op_code;
      ops = {ops, it};
    end

    // Overlap length: none, huge, random, exactly the mate's reference span, or 1 to span+5.
    r = $urandom_range(0, 99);
    if (r < 15)      skip = '0;
    else if (r < 25) skip = cotm_pkg::LenMax;
    else if (r < 35) skip = cotm_pkg::len_t'($urandom);
    else if (r < 60) skip = (ref_total > cotm_pkg::LenMax) ? cotm_pkg::LenMax :
                                                             cotm_pkg::len_t'(ref_total);
    else             skip = cotm_pkg::len_t'($urandom_range(1,
                              (ref_total > 32'h0fff_0000) ? 32'h0fff_0000 :
                                                            int'(ref_total) + 5));

    foreach (ops[k]) begin
      if (ops[k].from_second) begin
        ops[k].skip_len = skip;
        break;
      end
    end

    foreach (ops[k]) drive_op(ops[k], 1'b0, '0);
    random_ops += ops.size();
    pairs_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed table, random pairs, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    clear_pair_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_directed();
    foreach (directed_rows[i])
      drive_op(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
    directed_ops = ops_sent;

    while (random_ops < RandomItems) begin
      // Run a stretch in the middle with no bubbles on either side.
      calm = (random_ops >= 300 && random_ops < 450);
      drive_random_pair();
    end
    calm       = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then give the block time to emit anything it should not.
    while (merged_ops_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (merged_ops_q.size() != 0) mismatches += merged_ops_q.size();

    $display("drove %0d ops (%0d directed) over %0d random pairs; checked %0d merged results",
             ops_sent, directed_ops, pairs_sent, results_seen);
    $display("%0d mismatches over %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("tb_cigar_overlap_trim_merge: PASS");
    end else begin
      $display("tb_cigar_overlap_trim_merge: FAIL");
    end
    $finish;
  end

endmodule

// ===== cigar_overlap_trim_merge.f =====
+incdir+rtl
rtl/cotm_pkg.sv
rtl/cotm_front.sv
rtl/cotm_queue.sv
rtl/cotm_back.sv
rtl/cigar_overlap_trim_merge.sv
rtl/cotm_checker.sv
sim/tb_cigar_overlap_trim_merge.sv
